// ===== rtl/m3ou_pkg.sv =====
package m3ou_pkg;
  typedef enum logic [2:0] {
    OP_ADD = 3'd0, OP_SUB = 3'd1, OP_MATMUL = 3'd2, OP_SCALAR = 3'd3,
    OP_MATVEC = 3'd4, OP_TRANSPOSE = 3'd5, OP_DET = 3'd6, OP_ADJ = 3'd7
  } op_t;
  localparam int ROW_W = 48;
  localparam int DIM = 3;
endpackage

// ===== rtl/m3ou_lane.sv =====
module m3ou_lane #(
  parameter int EW = 16,
  parameter int PW = 2 * EW + 3
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [EW-1:0] x0, x1, x2,
  input  logic signed [EW-1:0] y0, y1, y2,
  input  logic signed [EW-1:0] z0, z1,
  input  logic                 sub,
  output logic signed [PW-1:0] dot_r,
  output logic signed [PW-1:0] dif_r
);
  logic signed [2*EW-1:0] p0, p1, p2, q0, q1;
  assign p0 = x0 * y0;
  assign p1 = x1 * y1;
  assign p2 = x2 * y2;
  assign q0 = x0 * z0;
  assign q1 = x1 * z1;
  always_ff @(posedge clk) begin
    if (en) begin
      dot_r <= PW'(p0) + PW'(p1) + PW'(p2);
      dif_r <= sub ? (PW'(q0) - PW'(q1)) : (PW'(q0) + PW'(q1));
    end
  end
endmodule

// ===== rtl/m3ou_merge.sv =====
module m3ou_merge #(
  parameter int EW = 16,
  parameter int W = 2 * EW + 3
) (
  input  logic signed [W-1:0] x,
  input  logic [5:0]          sh,
  output logic [EW-1:0]       y,
  output logic                sat
);
  logic signed [W-1:0] s;
  localparam logic signed [W-1:0] HI = W'((64'sd1 <<< (EW - 1)) - 1);
  localparam logic signed [W-1:0] LO = -HI - W'(1);
  always_comb begin
    s = x >>> sh;
    sat = 1'b0;
    y = s[EW-1:0];
    if (s > HI) begin
      y = HI[EW-1:0];
      sat = 1'b1;
    end else if (s < LO) begin
      y = LO[EW-1:0];
      sat = 1'b1;
    end
  end
endmodule

// ===== rtl/matrix3_operation_unit_core.sv =====
// 3x3 matrix arithmetic unit, fixed point elements of ELEM_WIDTH bits with
// FRAC_BITS fraction bits, three elements packed per 48 bit row.
// in channel: one word per request, operation code in in_tuser.
// out channel: one word per request, saturation flag in out_tuser.
// nine lanes of multipliers form all dot products and cofactors in the
// first stage; the determinant needs a second multiply stage.
// three register stages, throughput one word per cycle unless out_tready
// stalls. the pipeline advances whenever the output register is empty or
// being taken, so a stall on out_tready holds every stage and drops
// in_tready in the same cycle.
// reset (rst_n low, synchronous) empties the pipeline; no other state.
module matrix3_operation_unit_core #(
  parameter int ELEM_WIDTH = 16,
  parameter int FRAC_BITS = 12
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [319:0] in_tdata,  // a_row0, a_row1, a_row2, b_row0, b_row1, b_row2, scalar_value
  input  logic [2:0]   in_tuser,  // req_type
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [159:0] out_tdata, // res_row0, res_row1, res_row2, det_value
  output logic         out_tuser  // sat_flag
);
  import m3ou_pkg::*;
  localparam int EW = ELEM_WIDTH;
  localparam int PW = 2 * EW + 3;
  localparam int DW = 3 * EW + 4;

  logic adv;
  logic v1_r, v2_r, v3_r;
  assign adv = !v3_r || out_tready;
  assign in_tready = adv;

  logic [3*EW-1:0] ar [3];
  logic [3*EW-1:0] br [3];
  logic signed [EW-1:0] a [3][3];
  logic signed [EW-1:0] b [3][3];
  logic signed [EW-1:0] sc;
  op_t op;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ar[i] = '0;
      br[i] = '0;
      ar[i][3*EW-1:0] = (3 * EW > 48) ? (3*EW)'(in_tdata[48*i +: 48])
                                       : in_tdata[48*i +: 3*EW];
      br[i] = (3 * EW > 48) ? (3*EW)'(in_tdata[48*(i+3) +: 48])
                            : in_tdata[48*(i+3) +: 3*EW];
      for (int j = 0; j < 3; j++) begin
        a[i][j] = ar[i][EW*j +: EW];
        b[i][j] = br[i][EW*j +: EW];
      end
    end
    sc = EW'(signed'(in_tdata[303:288]));
    op = op_t'(in_tuser);
  end

  // lane operands: lane (i,j) produces result element r[i][j]
  logic signed [EW-1:0] lx [9][3];
  logic signed [EW-1:0] ly [9][3];
  logic signed [EW-1:0] lz [9][2];
  logic                 lsub;
  logic signed [PW-1:0] dot_r [9];
  logic signed [PW-1:0] dif_r [9];
  always_comb begin
    lsub = (op == OP_SUB) || (op == OP_ADJ) || (op == OP_DET);
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        for (int k = 0; k < 3; k++) begin
          lx[3*i+j][k] = '0;
          ly[3*i+j][k] = '0;
        end
        lz[3*i+j][0] = '0;
        lz[3*i+j][1] = '0;
        unique case (op)
          OP_ADD, OP_SUB: begin
            lx[3*i+j][0] = a[i][j];
            lx[3*i+j][1] = b[i][j];
            lz[3*i+j][0] = EW'(1);
            lz[3*i+j][1] = EW'(1);
          end
          OP_TRANSPOSE: begin
            lx[3*i+j][0] = a[j][i];
            ly[3*i+j][0] = EW'(1);
          end
          OP_MATMUL: begin
            for (int k = 0; k < 3; k++) begin
              lx[3*i+j][k] = a[k][j];
              ly[3*i+j][k] = b[i][k];
            end
          end
          OP_SCALAR: begin
            lx[3*i+j][0] = a[i][j];
            ly[3*i+j][0] = sc;
          end
          OP_MATVEC: begin
            if (i == 0) begin
              for (int k = 0; k < 3; k++) begin
                lx[3*i+j][k] = a[j][k];
                ly[3*i+j][k] = b[0][k];
              end
            end
          end
          OP_DET, OP_ADJ: begin
            // cofactor of a[j][i] placed at r[i][j]
            lx[3*i+j][0] = a[(j+1)%3][(i+1)%3];
            lz[3*i+j][0] = a[(j+2)%3][(i+2)%3];
            lx[3*i+j][1] = a[(j+2)%3][(i+1)%3];
            lz[3*i+j][1] = a[(j+1)%3][(i+2)%3];
          end
          default: ;
        endcase
      end
    end
  end

  for (genvar g = 0; g < 9; g++) begin : g_lane
    m3ou_lane #(.EW(EW), .PW(PW)) u_lane (
      .clk(clk), .en(adv),
      .x0(lx[g][0]), .x1(lx[g][1]), .x2(lx[g][2]),
      .y0(ly[g][0]), .y1(ly[g][1]), .y2(ly[g][2]),
      .z0(lz[g][0]), .z1(lz[g][1]), .sub(lsub),
      .dot_r(dot_r[g]), .dif_r(dif_r[g])
    );
  end

  op_t op1_r, op2_r;
  logic signed [EW-1:0] a0_r [3];
  always_ff @(posedge clk) begin
    if (adv) begin
      op1_r <= op;
      for (int k = 0; k < 3; k++) a0_r[k] <= a[0][k];
    end
  end

  // stage 2: pick element sums, determinant products
  logic signed [PW-1:0] el_nxt [9];
  logic signed [PW-1:0] el_r [9];
  logic signed [DW-1:0] dp_r [3];
  always_comb begin
    for (int g = 0; g < 9; g++) begin
      el_nxt[g] = ((op1_r == OP_ADD) || (op1_r == OP_SUB) || (op1_r == OP_ADJ))
                  ? dif_r[g] : dot_r[g];
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      op2_r <= op1_r;
      for (int g = 0; g < 9; g++) el_r[g] <= el_nxt[g];
      // det = sum_k a[0][k] * cofactor(0,k); cofactor(0,k) sits at lane (k,0)
      for (int k = 0; k < 3; k++) dp_r[k] <= DW'(a0_r[k]) * DW'(dif_r[3*k]);
    end
  end

  // stage 3: shift, saturate, pack
  logic [5:0] sh;
  logic [EW-1:0] ey [9];
  logic          es [9];
  logic signed [DW-1:0] dsum;
  logic signed [DW-1:0] dsh;
  logic [EW-1:0] dval;
  logic          dsat;
  localparam logic signed [DW-1:0] DHI = DW'((64'sd1 <<< (EW - 1)) - 1);
  localparam logic signed [DW-1:0] DLO = -DHI - DW'(1);
  always_comb begin
    sh = ((op2_r == OP_ADD) || (op2_r == OP_SUB) || (op2_r == OP_TRANSPOSE))
         ? 6'd0 : 6'(FRAC_BITS);
    dsum = dp_r[0] + dp_r[1] + dp_r[2];
    dsh = dsum >>> (2 * FRAC_BITS);
    dval = dsh[EW-1:0];
    dsat = 1'b0;
    if (dsh > DHI) begin
      dval = DHI[EW-1:0];
      dsat = 1'b1;
    end else if (dsh < DLO) begin
      dval = DLO[EW-1:0];
      dsat = 1'b1;
    end
  end
  for (genvar g = 0; g < 9; g++) begin : g_mrg
    m3ou_merge #(.EW(EW), .W(PW)) u_mrg (
      .x(el_r[g]), .sh(sh), .y(ey[g]), .sat(es[g])
    );
  end

  logic [3*EW-1:0] row [3];
  logic [159:0] data_nxt;
  logic         flag_nxt;
  always_comb begin
    data_nxt = '0;
    flag_nxt = 1'b0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) row[i][EW*j +: EW] = ey[3*i+j];
    end
    if (op2_r == OP_DET) begin
      data_nxt[159:144] = 16'(signed'(dval));
      flag_nxt = dsat;
    end else begin
      for (int i = 0; i < 3; i++) begin
        if (op2_r != OP_MATVEC || i == 0) begin
          data_nxt[48*i +: 48] = (3 * EW > 48) ? row[i][47:0] : 48'(row[i]);
          for (int j = 0; j < 3; j++) flag_nxt = flag_nxt | es[3*i+j];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_tvalid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      out_tdata <= data_nxt;
      out_tuser <= flag_nxt;
    end
  end
  assign out_tvalid = v3_r;

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output changed under stall");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("in_tready mismatch");
  a_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready ##1 in_tready ##1 in_tready |=> out_tvalid)
    else $error("word lost in pipeline");
endmodule

// ===== test/matrix3_operation_checker.sv =====
`timescale 1ns / 100ps

module matrix3_operation_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [319:0] in_tdata,
  input  logic [2:0]   in_tuser,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [159:0] out_tdata,
  input  logic         out_tuser,
  output int           fail_count,
  output int           pending
);
  import m3ou_pkg::*;

  localparam int EW = 16;
  localparam int FB = 12;

  typedef struct packed {
    logic [47:0] r0;
    logic [47:0] r1;
    logic [47:0] r2;
    logic [15:0] det;
    logic        sat;
  } matrix_result_t;

  matrix_result_t expected_q[$];
  bit clipped;

  function automatic longint elem_of(logic [47:0] row, int idx);
    logic signed [15:0] e;
    e = row[idx*EW +: EW];
    return longint'(e);
  endfunction

  function automatic longint clip16(longint x);
    if (x > 32767) begin
      clipped = 1;
      return 32767;
    end
    if (x < -32768) begin
      clipped = 1;
      return -32768;
    end
    return x;
  endfunction

  function automatic logic [47:0] pack3(longint v0, longint v1, longint v2);
    logic [15:0] e0, e1, e2;
    e0 = v0[15:0];
    e1 = v1[15:0];
    e2 = v2[15:0];
    return {e2, e1, e0};
  endfunction

  function automatic matrix_result_t compute_matrix_op(logic [319:0] d, op_t op);
    longint a[3][3], b[3][3], r[3][3];
    longint s, sc, det;
    logic signed [15:0] sc16;
    matrix_result_t res;
    int i1, i2, j1, j2;
    det = 0;
    clipped = 0;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        a[i][j] = elem_of(d[i*48 +: 48], j);
        b[i][j] = elem_of(d[(3+i)*48 +: 48], j);
        r[i][j] = 0;
      end
    sc16 = d[303:288];
    sc = longint'(sc16);
    case (op)
      OP_ADD, OP_SUB: begin
        for (int i = 0; i < 3; i++)
          for (int j = 0; j < 3; j++)
            r[i][j] = clip16(op == OP_ADD ? a[i][j] + b[i][j] : a[i][j] - b[i][j]);
      end
      OP_MATMUL: begin
        for (int j = 0; j < 3; j++)
          for (int i = 0; i < 3; i++) begin
            s = 0;
            for (int k = 0; k < 3; k++) s += a[k][i] * b[j][k];
            r[j][i] = clip16(s >>> FB);
          end
      end
      OP_SCALAR: begin
        for (int i = 0; i < 3; i++)
          for (int j = 0; j < 3; j++) r[i][j] = clip16((a[i][j] * sc) >>> FB);
      end
      OP_MATVEC: begin
        for (int j = 0; j < 3; j++) begin
          s = 0;
          for (int i = 0; i < 3; i++) s += a[j][i] * b[0][i];
          r[0][j] = clip16(s >>> FB);
        end
      end
      OP_TRANSPOSE: begin
        for (int i = 0; i < 3; i++)
          for (int j = 0; j < 3; j++) r[i][j] = a[j][i];
      end
      OP_DET: begin
        s = a[0][0] * (a[1][1] * a[2][2] - a[1][2] * a[2][1])
          - a[0][1] * (a[1][0] * a[2][2] - a[1][2] * a[2][0])
          + a[0][2] * (a[1][0] * a[2][1] - a[1][1] * a[2][0]);
        det = clip16(s >>> (2 * FB));
      end
      default: begin
        for (int i = 0; i < 3; i++)
          for (int j = 0; j < 3; j++) begin
            i1 = (i + 1) % 3;
            i2 = (i + 2) % 3;
            j1 = (j + 1) % 3;
            j2 = (j + 2) % 3;
            s = a[i1][j1] * a[i2][j2] - a[i2][j1] * a[i1][j2];
            r[j][i] = clip16(s >>> FB);
          end
      end
    endcase
    res.r0 = pack3(r[0][0], r[0][1], r[0][2]);
    res.r1 = pack3(r[1][0], r[1][1], r[1][2]);
    res.r2 = pack3(r[2][0], r[2][1], r[2][2]);
    res.det = det[15:0];
    res.sat = clipped;
    return res;
  endfunction

  initial fail_count = 0;
  assign pending = expected_q.size();

  always @(posedge clk) begin
    matrix_result_t exp_w;
    if (rst_n && in_tvalid && in_tready)
      expected_q = {expected_q, compute_matrix_op(in_tdata, op_t'(in_tuser))};
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result word %h", out_tdata);
        fail_count++;
      end else begin
        exp_w = expected_q.pop_front();
        if (out_tdata[47:0] !== exp_w.r0) begin
          $error("res_row0 expected %h actual %h", exp_w.r0, out_tdata[47:0]);
          fail_count++;
        end
        if (out_tdata[95:48] !== exp_w.r1) begin
          $error("res_row1 expected %h actual %h", exp_w.r1, out_tdata[95:48]);
          fail_count++;
        end
        if (out_tdata[143:96] !== exp_w.r2) begin
          $error("res_row2 expected %h actual %h", exp_w.r2, out_tdata[143:96]);
          fail_count++;
        end
        if (out_tdata[159:144] !== exp_w.det) begin
          $error("det_value expected %h actual %h", exp_w.det, out_tdata[159:144]);
          fail_count++;
        end
        if (out_tuser !== exp_w.sat) begin
          $error("sat_flag expected %b actual %b", exp_w.sat, out_tuser);
          fail_count++;
        end
      end
    end
  end

endmodule

// ===== test/tb_matrix3_operation_unit_core.sv =====
`timescale 1ns / 100ps

module tb_matrix3_operation_unit_core;
  import m3ou_pkg::*;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [319:0] in_tdata;
  logic [2:0]   in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [159:0] out_tdata;
  logic         out_tuser;
  int           fail_count;
  int           pending;
  int           send_idle_pct;
  int           recv_idle_pct;

  matrix3_operation_unit_core DUT (.*);

  matrix3_operation_checker checker_i (.*);

  initial clk = 0;
  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  initial begin
    #5ms;
    $display("FAILED: results differ");
    $finish;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic logic [15:0] pick_elem();
    case ($urandom_range(7))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'h1000;
      4: return 16'hf000;
      5: return 16'(($urandom_range(8191)) - 4096);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [319:0] random_word();
    logic [319:0] d;
    d = '0;
    for (int k = 0; k < 19; k++) d[k*16 +: 16] = pick_elem();
    return d;
  endfunction

  task automatic send_word(op_t op, logic [319:0] d);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 0;
      @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= d;
    in_tuser <= op;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  initial begin
    logic [319:0] d;
    int waited;
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = '0;
    in_tuser = OP_ADD;
    out_tready = 0;
    send_idle_pct = 23;
    recv_idle_pct = 72;
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // directed: each op on all-max, all-min and identity-ish values
    for (int op = 0; op < 8; op++) begin
      send_word(op_t'(op), {16'h0, {18{16'h7fff}}, 16'h7fff});
      send_word(op_t'(op), {16'h0, {19{16'h8000}}});
      send_word(op_t'(op), {16'h0, 16'h8000, {3{16'h0000, 16'h0000, 16'h1000}},
                            {3{16'h1000, 16'h0000, 16'h0000}}});
    end
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 23 : (phase == 1) ? 72 : 0;
      recv_idle_pct = (phase == 0) ? 72 : (phase == 1) ? 23 : 0;
      for (int n = 0; n < 250; n++) begin
        d = random_word();
        if ($urandom_range(1)) d[319:304] = 16'($urandom);
        send_word(op_t'($urandom_range(7)), d);
      end
    end
    in_tvalid <= 0;
    waited = 0;
    while (pending != 0 && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== matrix3_operation_unit_core.f =====
rtl/m3ou_pkg.sv
rtl/m3ou_lane.sv
rtl/m3ou_merge.sv
rtl/matrix3_operation_unit_core.sv
test/matrix3_operation_checker.sv
test/tb_matrix3_operation_unit_core.sv
